>>> rtl/mtpm_pkg.sv
// shared constants, slot layout and state encoding for the multibit trie prefix matcher
// no dependencies; used by mtpm_ram users and multibit_trie_prefix_match
package mtpm_pkg;

	localparam int STRIDE     = 4;
	localparam int NODE_COUNT = 4096;
	localparam int ADDR_BITS  = 128;

	localparam int SLOTS  = 1 << STRIDE;
	localparam int NODE_W = $clog2(NODE_COUNT);
	localparam int IDX_W  = NODE_W + STRIDE;
	localparam int DEPTH  = NODE_COUNT * SLOTS;
	localparam int PM_W   = (STRIDE > 1) ? STRIDE - 1 : 1;
	localparam int PM_IW  = (PM_W > 1) ? $clog2(PM_W) : 1;
	localparam int R_W    = $clog2(STRIDE + 2);
	localparam int LEN_W  = 8;

	typedef struct packed {
		logic [PM_W-1:0]   pmask;
		logic              leaf;
		logic [NODE_W-1:0] child;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_INS_RD,
		S_INS_EV,
		S_LK,
		S_DONE
	} state_t;

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_LOOKUP = 1'b1;

	// top r bits of a stride window kept, the rest zero padded
	function automatic logic [STRIDE-1:0] keep_mask(input logic [R_W-1:0] r);
		logic [STRIDE-1:0] m;
		m = '0;
		for (int k = 0; k < STRIDE; k++) begin
			m[STRIDE-1-k] = (R_W'(k) < r);
		end
		return m;
	endfunction

endpackage

>>> rtl/mtpm_ram.sv
// generic single-port synchronous ram with registered read
// no dependencies
module mtpm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end else begin
			rdata <= mem[addr];
		end
	end

endmodule

>>> rtl/multibit_trie_prefix_match.sv
// multibit trie longest-prefix match over 128-bit addresses, top level
// depends on mtpm_pkg and mtpm_ram
//
// One beat in, one beat out. An insert (func 0) walks the prefix a stride at
// a time, allocating child nodes from the pool, and marks the last stride as
// a full leaf or a partial length; it answers match_len 0 and table_full set
// when the pool ran dry. A lookup (func 1) walks down the levels until a slot
// has no child or the address ends, and answers the longest stored prefix
// length that matches, or 0. All slots live in one single-port ram of
// NODE_COUNT * 2^STRIDE entries with a registered read, so the ram port sets
// the pace: a lookup issues w reads per level, pipelined back to back; an
// insert reads one slot per level it touches and writes it back when it marks
// or allocates. One item is in flight at a time; in_stall is low only when
// the walker is idle, and a finished result waits in the output register.
// After reset a clearing pass writes every slot to zero before the first beat
// is taken.
module multibit_trie_prefix_match (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       func,
	input  logic [63:0]                addr_high,
	input  logic [63:0]                addr_low,
	input  logic [mtpm_pkg::LEN_W-1:0] prefix_len,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [mtpm_pkg::LEN_W-1:0] match_len,
	output logic                       table_full
);

	mtpm_pkg::state_t state_q, state_d;

	logic [mtpm_pkg::ADDR_BITS-1:0] addr_q;     // shifted left a stride per level
	logic [mtpm_pkg::LEN_W-1:0]     len_q;
	logic [mtpm_pkg::LEN_W-1:0]     pos_q;
	logic [mtpm_pkg::NODE_W-1:0]    node_q;
	logic [mtpm_pkg::R_W-1:0]       r_q;        // lookup read counter within a level
	logic [mtpm_pkg::LEN_W-1:0]     best_q;
	logic                           func_q;
	logic                           full_q;
	logic [mtpm_pkg::NODE_W:0]      used_q;
	logic [mtpm_pkg::IDX_W-1:0]     clr_q;

	logic                           out_valid_q;
	logic [mtpm_pkg::LEN_W-1:0]     match_len_q;
	logic                           table_full_q;

	// ram port
	logic                        ram_we;
	logic [mtpm_pkg::IDX_W-1:0]  ram_addr;
	mtpm_pkg::slot_t             ram_wdata;
	mtpm_pkg::slot_t             ram_rdata;

	// level geometry
	logic [mtpm_pkg::LEN_W-1:0]  rem;
	logic [mtpm_pkg::R_W-1:0]    w;
	logic [mtpm_pkg::LEN_W-1:0]  len_rem;
	logic                        ins_last;
	logic [mtpm_pkg::R_W-1:0]    r_ins;
	logic [mtpm_pkg::R_W-1:0]    r_keep;
	logic [mtpm_pkg::STRIDE-1:0] window;
	logic [mtpm_pkg::R_W-1:0]    r_prev;
	logic                        lk_hit;
	logic                        lk_end;
	logic [mtpm_pkg::LEN_W:0]    pos_next;
	logic                        accept;
	logic                        out_free;
	logic [mtpm_pkg::LEN_W-1:0]  len_sat;

	mtpm_ram #(
		.WIDTH (mtpm_pkg::SLOT_W),
		.DEPTH (mtpm_pkg::DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign len_sat  = (prefix_len > mtpm_pkg::LEN_W'(mtpm_pkg::ADDR_BITS)) ?
		mtpm_pkg::LEN_W'(mtpm_pkg::ADDR_BITS) : prefix_len;

	// width of the current level, short only at the tail when the stride does not divide 128
	assign rem = mtpm_pkg::LEN_W'(mtpm_pkg::ADDR_BITS) - pos_q;
	assign w   = (rem < mtpm_pkg::LEN_W'(mtpm_pkg::STRIDE)) ?
		mtpm_pkg::R_W'(rem) : mtpm_pkg::R_W'(mtpm_pkg::STRIDE);

	// insert: prefix ends within this level
	assign len_rem  = len_q - pos_q;
	assign ins_last = len_rem <= mtpm_pkg::LEN_W'(w);
	assign r_ins    = mtpm_pkg::R_W'(len_rem);

	assign window = addr_q[mtpm_pkg::ADDR_BITS-1 -: mtpm_pkg::STRIDE];
	assign r_keep = (state_q == mtpm_pkg::S_LK) ? r_q :
		(ins_last ? r_ins : mtpm_pkg::R_W'(mtpm_pkg::STRIDE));

	// lookup: data on the port belongs to the read issued in the previous cycle
	assign r_prev = r_q - mtpm_pkg::R_W'(1);
	always_comb begin
		if (r_prev == mtpm_pkg::R_W'(mtpm_pkg::STRIDE)) begin
			lk_hit = ram_rdata.leaf;
		end else begin
			lk_hit = ram_rdata.pmask[mtpm_pkg::PM_IW'(r_prev - mtpm_pkg::R_W'(1))];
		end
	end
	assign lk_end   = r_q == (w + mtpm_pkg::R_W'(1));
	assign pos_next = {1'b0, pos_q} + (mtpm_pkg::LEN_W + 1)'(w);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mtpm_pkg::S_CLEAR: begin
				if (clr_q == '1) begin
					state_d = mtpm_pkg::S_IDLE;
				end
			end
			mtpm_pkg::S_IDLE: begin
				if (accept) begin
					if (func == mtpm_pkg::FUNC_LOOKUP) begin
						state_d = mtpm_pkg::S_LK;
					end else if (len_sat == '0) begin
						state_d = mtpm_pkg::S_DONE;
					end else begin
						state_d = mtpm_pkg::S_INS_RD;
					end
				end
			end
			mtpm_pkg::S_INS_RD: begin
				state_d = mtpm_pkg::S_INS_EV;
			end
			mtpm_pkg::S_INS_EV: begin
				if (ins_last) begin
					state_d = mtpm_pkg::S_DONE;
				end else if (ram_rdata.child == '0 &&
						used_q == (mtpm_pkg::NODE_W + 1)'(mtpm_pkg::NODE_COUNT)) begin
					state_d = mtpm_pkg::S_DONE;
				end else begin
					state_d = mtpm_pkg::S_INS_RD;
				end
			end
			mtpm_pkg::S_LK: begin
				if (lk_end && (ram_rdata.child == '0 ||
						pos_next >= (mtpm_pkg::LEN_W + 1)'(mtpm_pkg::ADDR_BITS))) begin
					state_d = mtpm_pkg::S_DONE;
				end
			end
			mtpm_pkg::S_DONE: begin
				if (out_free) begin
					state_d = mtpm_pkg::S_IDLE;
				end
			end
			default: state_d = mtpm_pkg::S_CLEAR;
		endcase
	end

	// ram control
	always_comb begin
		ram_we    = 1'b0;
		ram_addr  = {node_q, window & mtpm_pkg::keep_mask(r_keep)};
		ram_wdata = ram_rdata;
		unique case (state_q)
			mtpm_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_addr  = clr_q;
				ram_wdata = '0;
			end
			mtpm_pkg::S_INS_EV: begin
				if (ins_last) begin
					ram_we = 1'b1;
					if (r_ins == mtpm_pkg::R_W'(mtpm_pkg::STRIDE)) begin
						ram_wdata.leaf = 1'b1;
					end else begin
						ram_wdata.pmask[mtpm_pkg::PM_IW'(r_ins - mtpm_pkg::R_W'(1))] = 1'b1;
					end
				end else if (ram_rdata.child == '0 &&
						used_q != (mtpm_pkg::NODE_W + 1)'(mtpm_pkg::NODE_COUNT)) begin
					ram_we          = 1'b1;
					ram_wdata.child = used_q[mtpm_pkg::NODE_W-1:0];
				end
			end
			mtpm_pkg::S_IDLE, mtpm_pkg::S_INS_RD, mtpm_pkg::S_LK, mtpm_pkg::S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign in_stall = state_q != mtpm_pkg::S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtpm_pkg::S_CLEAR;
			clr_q       <= '0;
			used_q      <= (mtpm_pkg::NODE_W + 1)'(1);
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == mtpm_pkg::S_CLEAR) begin
				clr_q <= clr_q + mtpm_pkg::IDX_W'(1);
			end
			if (state_q == mtpm_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == mtpm_pkg::S_INS_EV && !ins_last && ram_rdata.child == '0 &&
					used_q != (mtpm_pkg::NODE_W + 1)'(mtpm_pkg::NODE_COUNT)) begin
				used_q <= used_q + (mtpm_pkg::NODE_W + 1)'(1);
			end
		end
	end

	// walker datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			mtpm_pkg::S_IDLE: begin
				if (accept) begin
					addr_q <= {addr_high, addr_low};
					len_q  <= len_sat;
					func_q <= func;
					pos_q  <= '0;
					node_q <= '0;
					r_q    <= mtpm_pkg::R_W'(1);
					best_q <= '0;
					full_q <= 1'b0;
				end
			end
			mtpm_pkg::S_INS_EV: begin
				if (!ins_last) begin
					if (ram_rdata.child != '0) begin
						node_q <= ram_rdata.child;
						pos_q  <= pos_next[mtpm_pkg::LEN_W-1:0];
						addr_q <= addr_q << mtpm_pkg::STRIDE;
					end else if (used_q == (mtpm_pkg::NODE_W + 1)'(mtpm_pkg::NODE_COUNT)) begin
						full_q <= 1'b1;
					end else begin
						node_q <= used_q[mtpm_pkg::NODE_W-1:0];
						pos_q  <= pos_next[mtpm_pkg::LEN_W-1:0];
						addr_q <= addr_q << mtpm_pkg::STRIDE;
					end
				end
			end
			mtpm_pkg::S_LK: begin
				if (r_q > mtpm_pkg::R_W'(1) && lk_hit) begin
					best_q <= pos_q + mtpm_pkg::LEN_W'(r_prev);
				end
				if (lk_end) begin
					node_q <= ram_rdata.child;
					pos_q  <= pos_next[mtpm_pkg::LEN_W-1:0];
					addr_q <= addr_q << mtpm_pkg::STRIDE;
					r_q    <= mtpm_pkg::R_W'(1);
				end else begin
					r_q <= r_q + mtpm_pkg::R_W'(1);
				end
			end
			mtpm_pkg::S_DONE: begin
				if (out_free) begin
					match_len_q  <= (func_q == mtpm_pkg::FUNC_LOOKUP) ? best_q : '0;
					table_full_q <= (func_q == mtpm_pkg::FUNC_INSERT) && full_q;
				end
			end
			mtpm_pkg::S_CLEAR, mtpm_pkg::S_INS_RD: begin
			end
			default: begin
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign match_len  = match_len_q;
	assign table_full = table_full_q;

endmodule

>>> rtl/mtpm_checker.sv
// port-level checks on the prefix matcher and the bind that attaches them
// depends on mtpm_pkg and multibit_trie_prefix_match
module mtpm_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [mtpm_pkg::LEN_W-1:0] match_len,
	input logic                       table_full
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(match_len) && $stable(table_full))
		else $error("stalled result changed");

	// only one item in flight: stall rises right after an accepted beat
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while walking");

	// a full pool only ever reports on an insert, which matches nothing
	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> match_len == '0)
		else $error("table_full with non-zero match");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> match_len <= mtpm_pkg::LEN_W'(mtpm_pkg::ADDR_BITS))
		else $error("match length beyond address width");

endmodule

bind multibit_trie_prefix_match mtpm_checker u_mtpm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.match_len  (match_len),
	.table_full (table_full)
);

>>> verif/multibit_trie_prefix_match_test.sv
// self-checking bench for multibit_trie_prefix_match: directed table, then random insert/lookup
// depends on mtpm_pkg and the block's rtl; holds its own trie predictor
`timescale 1ns / 1ps

module multibit_trie_prefix_match_test;

	localparam int POOL  = mtpm_pkg::NODE_COUNT;
	localparam int WAYS  = mtpm_pkg::SLOTS;
	localparam int N_RND = 1030;

	typedef struct {
		logic              func;
		logic [127:0]      addr;
		logic [7:0]        len;
		bit                known;   // expectation typed into the table
		logic [7:0]        exp_len;
		logic              exp_full;
	} row_t;

	typedef struct {
		logic [7:0] len;
		logic       full;
	} answer_t;

	typedef struct {
		logic [127:0] addr;
		int           len;
	} prefix_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic                          func = mtpm_pkg::FUNC_INSERT;
	logic [63:0]                   addr_high = '0;
	logic [63:0]                   addr_low = '0;
	logic [mtpm_pkg::LEN_W-1:0]    prefix_len = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [mtpm_pkg::LEN_W-1:0]    match_len;
	logic                          table_full;

	// predictor copy of the trie: per slot a child index, a leaf bit and a partial mask
	int unsigned         trie_child [POOL*WAYS];
	bit                  trie_leaf  [POOL*WAYS];
	bit [mtpm_pkg::PM_W-1:0] trie_pmask [POOL*WAYS];
	int unsigned         trie_nodes;

	answer_t             answers_due [$];
	prefix_t             stored [$];
	row_t                dir_rows [$];

	int                  errors = 0;
	int                  beats_out = 0;
	int                  n_ins = 0, n_lk = 0, n_full = 0, n_hit = 0;
	int                  hold_left = 0;
	bit                  held_once = 1'b0;
	bit                  sending_done = 1'b0;

	multibit_trie_prefix_match dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .addr_high(addr_high), .addr_low(addr_low), .prefix_len(prefix_len),
		.out_valid(out_valid), .out_stall(out_stall),
		.match_len(match_len), .table_full(table_full)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// generous ceiling: clearing pass plus every beat at its slowest with stalls
	initial begin
		#30ms;
		$display("Verification failed");
		$finish;
	end

	// window of 'keep' address bits from bit position pos (0 = msb), zero padded
	function automatic int unsigned way_of(logic [127:0] a, int pos, int keep);
		int unsigned v;
		v = 0;
		for (int k = 0; k < mtpm_pkg::STRIDE; k++) begin
			v = v << 1;
			if (k < keep && pos + k < 128)
				v = v | 32'(a[127-pos-k]);
		end
		return v;
	endfunction

	function automatic logic trie_insert(logic [127:0] a, int len_in);
		int unsigned node, s;
		int pos, w, r, len;
		node = 0;
		pos = 0;
		len = (len_in > 128) ? 128 : len_in;
		if (len == 0)
			return 1'b0;
		forever begin
			w = (128 - pos < mtpm_pkg::STRIDE) ? 128 - pos : mtpm_pkg::STRIDE;
			if (len - pos <= w) begin
				r = len - pos;
				s = node * WAYS + way_of(a, pos, r);
				if (r == mtpm_pkg::STRIDE)
					trie_leaf[s] = 1'b1;
				else
					trie_pmask[s][r-1] = 1'b1;
				return 1'b0;
			end
			s = node * WAYS + way_of(a, pos, mtpm_pkg::STRIDE);
			if (trie_child[s] == 0) begin
				// pool dry: stop here, nodes already taken stay
				if (trie_nodes >= POOL)
					return 1'b1;
				trie_child[s] = trie_nodes;
				trie_nodes++;
			end
			node = trie_child[s];
			pos += mtpm_pkg::STRIDE;
		end
	endfunction

	function automatic logic [7:0] trie_longest(logic [127:0] a);
		int unsigned node, s, nxt;
		int pos, w, best;
		node = 0;
		pos = 0;
		best = 0;
		while (pos < 128) begin
			w = (128 - pos < mtpm_pkg::STRIDE) ? 128 - pos : mtpm_pkg::STRIDE;
			for (int r = 1; r <= w; r++) begin
				s = node * WAYS + way_of(a, pos, r);
				if (r == mtpm_pkg::STRIDE) begin
					if (trie_leaf[s])
						best = pos + r;
				end else if (trie_pmask[s][r-1]) begin
					best = pos + r;
				end
			end
			nxt = trie_child[node * WAYS + way_of(a, pos, w)];
			if (nxt == 0 || nxt >= trie_nodes)
				break;
			node = nxt;
			pos += w;
		end
		return best[7:0];
	endfunction

	function automatic logic [127:0] rand_addr();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// lookups and inserts at even odds, mostly near stored prefixes and sharing their paths, some noise
	function automatic row_t random_row();
		row_t         rw;
		logic [127:0] base, keep;
		int           p, sel;
		rw.known = 1'b0;
		rw.exp_len = '0;
		rw.exp_full = 1'b0;
		base = rand_addr();
		if (stored.size() > 0 && $urandom_range(0, 9) < 7) begin
			prefix_t pf;
			pf = stored[$urandom_range(0, stored.size() - 1)];
			p = pf.len + $urandom_range(0, 16) - 8;
			if (p < 0)
				p = 0;
			if (p > 128)
				p = 128;
			keep = (p == 0) ? '0 : ~128'd0 << (128 - p);
			base = (pf.addr & keep) | (base & ~keep);
		end
		rw.addr = base;
		rw.func = ($urandom_range(0, 1) == 0) ? mtpm_pkg::FUNC_INSERT : mtpm_pkg::FUNC_LOOKUP;
		sel = $urandom_range(0, 19);
		if (sel < 12)
			rw.len = 8'($urandom_range(1, 40));
		else if (sel < 17)
			rw.len = 8'($urandom_range(41, 128));
		else if (sel < 19)
			rw.len = 8'($urandom_range(129, 255));
		else
			rw.len = 8'd0;
		return rw;
	endfunction

	task automatic add_row(logic f, logic [127:0] a, logic [7:0] l, bit k, logic [7:0] el,
		logic ef);
		row_t rw;
		rw.func = f;
		rw.addr = a;
		rw.len = l;
		rw.known = k;
		rw.exp_len = el;
		rw.exp_full = ef;
		dir_rows.push_back(rw);
	endtask

	// offer one beat and hold it until taken; the expectation is queued on acceptance
	task automatic send_beat(row_t rw, bit may_idle);
		answer_t ans;
		if (may_idle && $urandom_range(0, 99) < 15) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= rw.func;
		addr_high <= rw.addr[127:64];
		addr_low <= rw.addr[63:0];
		prefix_len <= rw.len;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (rw.func == mtpm_pkg::FUNC_INSERT) begin
			ans.full = trie_insert(rw.addr, int'(rw.len));
			ans.len = 8'd0;
			n_ins++;
			if (ans.full)
				n_full++;
			else if (rw.len != 0)
				stored.push_back('{rw.addr, (rw.len > 128) ? 128 : int'(rw.len)});
		end else begin
			ans.len = trie_longest(rw.addr);
			ans.full = 1'b0;
			n_lk++;
			if (ans.len != 0)
				n_hit++;
		end
		if (rw.known) begin
			ans.len = rw.exp_len;
			ans.full = rw.exp_full;
		end
		answers_due.push_back(ans);
	endtask

	// sender
	initial begin
		logic [127:0] ones, top1;
		int           wait_cycles;
		ones = ~128'd0;
		top1 = 128'd1 << 127;
		trie_nodes = 1;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// empty trie, extremes of address and length
		add_row(mtpm_pkg::FUNC_LOOKUP, '0,   8'd0,   1, 8'd0,   1'b0);
		add_row(mtpm_pkg::FUNC_LOOKUP, ones, 8'd255, 1, 8'd0,   1'b0);
		add_row(mtpm_pkg::FUNC_INSERT, ones, 8'd0,   1, 8'd0,   1'b0);  // zero length stores nothing
		add_row(mtpm_pkg::FUNC_LOOKUP, ones, 8'd0,   1, 8'd0,   1'b0);
		add_row(mtpm_pkg::FUNC_INSERT, ones, 8'd128, 1, 8'd0,   1'b0);
		add_row(mtpm_pkg::FUNC_LOOKUP, ones, 8'd0,   1, 8'd128, 1'b0);
		add_row(mtpm_pkg::FUNC_INSERT, '0,   8'd255, 1, 8'd0,   1'b0);  // saturated to full length
		add_row(mtpm_pkg::FUNC_LOOKUP, '0,   8'd7,   1, 8'd128, 1'b0);
		// partial lengths sharing one padded slot, then a full stride leaf
		add_row(mtpm_pkg::FUNC_INSERT, top1, 8'd1,   1, 8'd0,   1'b0);
		add_row(mtpm_pkg::FUNC_INSERT, top1, 8'd2,   1, 8'd0,   1'b0);
		add_row(mtpm_pkg::FUNC_INSERT, top1, 8'd3,   1, 8'd0,   1'b0);
		add_row(mtpm_pkg::FUNC_LOOKUP, top1, 8'd0,   0, 8'd0,   1'b0);
		add_row(mtpm_pkg::FUNC_INSERT, top1, 8'd4,   1, 8'd0,   1'b0);
		add_row(mtpm_pkg::FUNC_INSERT, top1, 8'd4,   1, 8'd0,   1'b0);  // repeated mark
		add_row(mtpm_pkg::FUNC_LOOKUP, top1 | 128'h1, 8'd0, 0, 8'd0, 1'b0);
		add_row(mtpm_pkg::FUNC_INSERT, top1, 8'd5,   1, 8'd0,   1'b0);
		add_row(mtpm_pkg::FUNC_LOOKUP, top1, 8'd0,   0, 8'd0,   1'b0);
		add_row(mtpm_pkg::FUNC_INSERT, 128'h5555_aaaa_0000_ffff_1234_5678_9abc_def0, 8'd127,
			1, 8'd0, 1'b0);
		add_row(mtpm_pkg::FUNC_LOOKUP, 128'h5555_aaaa_0000_ffff_1234_5678_9abc_def1, 8'd0,
			0, 8'd0, 1'b0);
		add_row(mtpm_pkg::FUNC_LOOKUP, 128'h5555_aaaa_0000_ffff_1234_5678_9abc_def0 ^ 128'h2,
			8'd0, 0, 8'd0, 1'b0);
		add_row(mtpm_pkg::FUNC_LOOKUP, ones ^ 128'h1, 8'd0, 0, 8'd0, 1'b0);
		foreach (dir_rows[i])
			send_beat(dir_rows[i], 1'b1);

		// pause until the block has drained everything
		in_valid <= 1'b0;
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat ($urandom_range(1, 20)) @(posedge clk);

		// random part; a stretch in the middle runs back to back
		for (int i = 0; i < N_RND; i++)
			send_beat(random_row(), !(i >= 400 && i < 600));
		in_valid <= 1'b0;
		sending_done = 1'b1;
	end

	// receiver: random stall, one long hold-off, a stall-free stretch, checks against the oldest expectation
	always @(posedge clk) begin
		answer_t ans;
		if (out_valid && !out_stall) begin
			beats_out <= beats_out + 1;
			if (answers_due.size() == 0) begin
				$error("result beat with nothing expected: match_len %0d table_full %0b",
					match_len, table_full);
				errors++;
			end else begin
				ans = answers_due.pop_front();
				if (match_len !== ans.len) begin
					$error("match_len expected %0d actual %0d", ans.len, match_len);
					errors++;
				end
				if (table_full !== ans.full) begin
					$error("table_full expected %0b actual %0b", ans.full, table_full);
					errors++;
				end
			end
		end
		if (!held_once && beats_out == 60) begin
			held_once <= 1'b1;
			hold_left <= 300;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (beats_out >= 420 && beats_out < 620) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 15);
		end
	end

	// end of run
	initial begin
		wait (sending_done);
		while (answers_due.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		$display("covered %0d inserts (%0d hit a dry pool) and %0d lookups (%0d matched)",
			n_ins, n_full, n_lk, n_hit);
		$display("trie holds %0d of %0d nodes, %0d result beats checked",
			trie_nodes, POOL, beats_out);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> filelist.f
rtl/mtpm_pkg.sv
rtl/mtpm_ram.sv
rtl/multibit_trie_prefix_match.sv
rtl/mtpm_checker.sv
verif/multibit_trie_prefix_match_test.sv
